// ===== sv/dzad_pkg.sv =====
// Shared types, register indexes and reset values of the distance zone alarm driver.
`default_nettype none

package dzad_pkg;

  // Field widths fixed by the block's interface.
  localparam int unsigned DIST_W   = 16;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned COUNT_W  = 4;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Defaults of the top-level parameters.
  localparam int unsigned TIME_WIDTH_DEF    = 16;
  localparam int unsigned MIDDLE_OFF_MS_DEF = 250;

  // Register reset values.
  localparam logic [LEN_W-1:0]   NEAR_LIMIT_RST   = 16'd100;
  localparam logic [LEN_W-1:0]   FAR_LIMIT_RST    = 16'd300;
  localparam logic [LEN_W-1:0]   FAST_BLINK_RST   = 16'd120;
  localparam logic [LEN_W-1:0]   SLOW_BLINK_RST   = 16'd500;
  localparam logic [COUNT_W-1:0] NEAR_COUNT_RST   = 4'd5;
  localparam logic [LEN_W-1:0]   NEAR_BEEP_RST    = 16'd100;
  localparam logic [COUNT_W-1:0] MIDDLE_COUNT_RST = 4'd3;
  localparam logic [LEN_W-1:0]   MIDDLE_ON_RST    = 16'd200;

  typedef enum logic [1:0] {
    ZONE_NONE    = 2'd0,
    ZONE_CLOSE   = 2'd1,
    ZONE_MID     = 2'd2,
    ZONE_DISTANT = 2'd3
  } zone_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NEAR_LIMIT   = 3'd0,
    CFG_FAR_LIMIT    = 3'd1,
    CFG_FAST_BLINK   = 3'd2,
    CFG_SLOW_BLINK   = 3'd3,
    CFG_NEAR_COUNT   = 3'd4,
    CFG_NEAR_BEEP    = 3'd5,
    CFG_MIDDLE_COUNT = 3'd6,
    CFG_MIDDLE_ON    = 3'd7
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== sv/dzad_intf.sv =====
// Handshake interfaces of the distance zone alarm driver: input, result and register write.
`default_nettype none

interface dzad_in_if import dzad_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              func;
  logic [DIST_W-1:0] distance_mm;

  modport source (output valid, output func, output distance_mm, input ready);
  modport sink   (input valid, input func, input distance_mm, output ready);
endinterface

interface dzad_out_if import dzad_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] zone;
  logic       led_on;
  logic       buzzer_on;
  logic       pattern_active;

  modport source (output valid, output zone, output led_on, output buzzer_on,
                  output pattern_active, input ready);
  modport sink   (input valid, input zone, input led_on, input buzzer_on,
                  input pattern_active, output ready);
endinterface

interface dzad_cfg_if import dzad_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/distance_zone_alarm_driver_unit.sv =====
// Top level of the distance zone alarm driver: zone classing, LED blinking and beep bursts.
`default_nettype none

// Each input beat is either a distance sample (func 0) or a one-millisecond
// tick (func 1), and each one yields exactly one result beat carrying the
// zone, the LED level, the buzzer level and whether a beep burst is still
// running. A beat is taken into an input register; once the result register
// is free or being emptied, a single pass of combinational logic updates the
// alarm state and loads the result register, so the block sustains one beat
// per clock while results are taken. The input register and the result
// register form two stages, so a new beat is still accepted while one result
// waits to be taken. The register port is always ready; registers should
// be written only while no beat is in flight. Elapsed counters are TIME_WIDTH
// bits wide and saturate, so a length or interval above their maximum is
// never reached.
module distance_zone_alarm_driver_unit
  import dzad_pkg::*;
#(
  parameter int unsigned TIME_WIDTH    = TIME_WIDTH_DEF,
  parameter int unsigned MIDDLE_OFF_MS = MIDDLE_OFF_MS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  dzad_in_if.sink     in_i,
  dzad_cfg_if.sink    cfg_i,
  dzad_out_if.source  out_o
);

  // Comparisons run at the wider of the counter and the programmed length, so
  // that a narrow counter never wraps into a match.
  localparam int unsigned CMP_W = (TIME_WIDTH > LEN_W) ? TIME_WIDTH : LEN_W;
  localparam logic [LEN_W-1:0] MIDDLE_OFF = LEN_W'(MIDDLE_OFF_MS);

  // Configuration registers.
  logic [LEN_W-1:0]   near_limit_q, far_limit_q, fast_blink_q, slow_blink_q;
  logic [COUNT_W-1:0] near_count_q, middle_count_q;
  logic [LEN_W-1:0]   near_beep_q, middle_on_q;

  // Input stage.
  logic              in_valid_q;
  logic              in_func_q;
  logic [DIST_W-1:0] in_dist_q;

  // Alarm state.
  zone_e                 zone_q, zone_d;
  logic                  led_q, led_d;
  logic [TIME_WIDTH-1:0] led_el_q, led_el_d;
  logic                  run_q, run_d;
  logic                  phase_q, phase_d;
  logic [COUNT_W-1:0]    target_q, target_d;
  logic [COUNT_W-1:0]    done_q, done_d;
  logic [LEN_W-1:0]      on_len_q, on_len_d;
  logic [LEN_W-1:0]      off_len_q, off_len_d;
  logic [TIME_WIDTH-1:0] beep_el_q, beep_el_d;

  // Result stage.
  logic       out_valid_q;
  logic [1:0] out_zone_q;
  logic       out_led_q, out_buzz_q, out_run_q;

  logic advance;

  // The stored beat moves on whenever the result register is free or being emptied.
  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  assign out_o.valid          = out_valid_q;
  assign out_o.zone           = out_zone_q;
  assign out_o.led_on         = out_led_q;
  assign out_o.buzzer_on      = out_buzz_q;
  assign out_o.pattern_active = out_run_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      near_limit_q   <= NEAR_LIMIT_RST;
      far_limit_q    <= FAR_LIMIT_RST;
      fast_blink_q   <= FAST_BLINK_RST;
      slow_blink_q   <= SLOW_BLINK_RST;
      near_count_q   <= NEAR_COUNT_RST;
      near_beep_q    <= NEAR_BEEP_RST;
      middle_count_q <= MIDDLE_COUNT_RST;
      middle_on_q    <= MIDDLE_ON_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_NEAR_LIMIT:   near_limit_q   <= cfg_i.data;
        CFG_FAR_LIMIT:    far_limit_q    <= cfg_i.data;
        CFG_FAST_BLINK:   fast_blink_q   <= cfg_i.data;
        CFG_SLOW_BLINK:   slow_blink_q   <= cfg_i.data;
        CFG_NEAR_COUNT:   near_count_q   <= cfg_i.data[COUNT_W-1:0];
        CFG_NEAR_BEEP:    near_beep_q    <= cfg_i.data;
        CFG_MIDDLE_COUNT: middle_count_q <= cfg_i.data[COUNT_W-1:0];
        CFG_MIDDLE_ON:    middle_on_q    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_func_q <= in_i.func;
      in_dist_q <= in_i.distance_mm;
    end
  end

  // One update of the whole alarm state per beat: first the tick or the
  // sample, then the buzzer sequencer, then the LED blinker.
  always_comb begin
    zone_e            z_sample;
    logic [LEN_W-1:0] interval;
    logic             blinking;

    zone_d    = zone_q;
    led_d     = led_q;
    led_el_d  = led_el_q;
    run_d     = run_q;
    phase_d   = phase_q;
    target_d  = target_q;
    done_d    = done_q;
    on_len_d  = on_len_q;
    off_len_d = off_len_q;
    beep_el_d = beep_el_q;

    if (in_dist_q < near_limit_q) begin
      z_sample = ZONE_CLOSE;
    end else if (in_dist_q < far_limit_q) begin
      z_sample = ZONE_MID;
    end else begin
      z_sample = ZONE_DISTANT;
    end

    if (in_func_q) begin
      // Millisecond tick: both elapsed counters advance and saturate.
      if (led_el_q != '1) begin
        led_el_d = led_el_q + TIME_WIDTH'(1);
      end
      if (beep_el_q != '1) begin
        beep_el_d = beep_el_q + TIME_WIDTH'(1);
      end
    end else if (z_sample != zone_q) begin
      // A change of zone restarts the LED and the burst.
      zone_d   = z_sample;
      led_d    = 1'b1;
      led_el_d = '0;
      run_d    = 1'b0;
      phase_d  = 1'b0;
      done_d   = '0;
      if (z_sample == ZONE_CLOSE || z_sample == ZONE_MID) begin
        run_d     = 1'b1;
        phase_d   = 1'b1;
        beep_el_d = '0;
        if (z_sample == ZONE_CLOSE) begin
          target_d  = near_count_q;
          on_len_d  = near_beep_q;
          off_len_d = near_beep_q;
        end else begin
          target_d  = middle_count_q;
          on_len_d  = middle_on_q;
          off_len_d = MIDDLE_OFF;
        end
      end
    end

    // Buzzer: at most one phase change per beat.
    if (run_d) begin
      if (phase_d) begin
        if (CMP_W'(beep_el_d) >= CMP_W'(on_len_d)) begin
          phase_d   = 1'b0;
          beep_el_d = '0;
          done_d    = done_d + COUNT_W'(1);
          if (done_d >= target_d) begin
            run_d = 1'b0;
          end
        end
      end else if (CMP_W'(beep_el_d) >= CMP_W'(off_len_d)) begin
        phase_d   = 1'b1;
        beep_el_d = '0;
      end
    end

    // LED: blinks in the near and middle zones, held on otherwise.
    blinking = 1'b1;
    case (zone_d)
      ZONE_CLOSE: interval = fast_blink_q;
      ZONE_MID:   interval = slow_blink_q;
      default: begin
        interval = '0;
        blinking = 1'b0;
      end
    endcase
    if (!blinking) begin
      led_d = 1'b1;
    end else if (CMP_W'(led_el_d) >= CMP_W'(interval)) begin
      led_el_d = '0;
      led_d    = !led_d;
    end
  end

  // Alarm state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_q    <= ZONE_NONE;
      led_q     <= 1'b1;
      led_el_q  <= '0;
      run_q     <= 1'b0;
      phase_q   <= 1'b0;
      target_q  <= '0;
      done_q    <= '0;
      on_len_q  <= '0;
      off_len_q <= '0;
      beep_el_q <= '0;
    end else if (advance) begin
      zone_q    <= zone_d;
      led_q     <= led_d;
      led_el_q  <= led_el_d;
      run_q     <= run_d;
      phase_q   <= phase_d;
      target_q  <= target_d;
      done_q    <= done_d;
      on_len_q  <= on_len_d;
      off_len_q <= off_len_d;
      beep_el_q <= beep_el_d;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_zone_q <= zone_d;
      out_led_q  <= led_d;
      out_buzz_q <= phase_d;
      out_run_q  <= run_d;
    end
  end

`ifndef SYNTHESIS
  // A burst only ever runs in the near or middle zone.
  a_run_zone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (zone_q == ZONE_CLOSE || zone_q == ZONE_MID))
    else $error("beep burst running outside near and middle zones");

  // The buzzer is never on once the burst has ended.
  a_phase_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q |-> run_q)
    else $error("buzzer on without a running burst");

  // The LED is steadily on in the far and unknown zones.
  a_led_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zone_q == ZONE_DISTANT || zone_q == ZONE_NONE) |-> led_q)
    else $error("LED off outside a blinking zone");

  // Once classed, the zone never falls back to unknown.
  a_zone_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (zone_q != ZONE_NONE) |=> (zone_q != ZONE_NONE))
    else $error("zone returned to unknown");
`endif

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// Self-checking testbench for the distance zone alarm driver: directed script, then random phases.
`timescale 1ns / 1ps

module testbench
  import dzad_pkg::*;
();

  // The block is instantiated with its default parameters, so the model below
  // uses the same counter width and middle zone off time.
  localparam int unsigned TW = TIME_WIDTH_DEF;
  localparam logic [LEN_W-1:0] MIDDLE_OFF = 16'(MIDDLE_OFF_MS_DEF);
  localparam int RANDOM_BEATS = 1950;

  // One result beat as the block presents it.
  typedef struct packed {
    zone_e zone;
    logic  led_on;
    logic  buzzer_on;
    logic  pattern_active;
  } alarm_result_t;

  typedef enum logic {ROW_BEAT, ROW_REG} row_kind_e;

  // A row of the directed script: either an input beat or a register write.
  // Where a beat's outcome is obvious, it is written into the row and compared
  // as it stands; otherwise the model supplies it.
  typedef struct {
    row_kind_e     kind;
    logic          func;
    logic [15:0]   value;
    cfg_idx_e      reg_sel;
    logic          typed;
    alarm_result_t typed_out;
  } script_row_t;

  typedef enum {STYLE_LOW, STYLE_HIGH, STYLE_MIXED} setting_style_e;

  localparam alarm_result_t UNTYPED = alarm_result_t'{ZONE_NONE, 1'b0, 1'b0, 1'b0};

  logic clk = 1'b0;
  logic rst_n;
  logic calm = 1'b0;   // when set, neither side inserts idle cycles

  dzad_in_if  in_bus ();
  dzad_cfg_if cfg_bus ();
  dzad_out_if out_bus ();

  distance_zone_alarm_driver_unit DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_bus),
    .cfg_i  (cfg_bus),
    .out_o  (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Alarm states that the block still owes, oldest first.
  alarm_result_t alarm_backlog[$];
  script_row_t   script[$];
  int            fault_count = 0;
  int            results_seen = 0;

  // Register copies held by the model.
  logic [LEN_W-1:0]   lim_near, lim_far, blink_fast, blink_slow, near_len, middle_on;
  logic [COUNT_W-1:0] count_near, count_middle;

  // Alarm state held by the model.
  zone_e              cur_zone;
  logic               led_lvl;
  logic [TW-1:0]      led_cnt;
  logic               burst_on;
  logic               beep_on;
  logic [COUNT_W-1:0] beep_goal;
  logic [COUNT_W-1:0] beeps_made;
  logic [LEN_W-1:0]   on_len, off_len;
  logic [TW-1:0]      beep_cnt;

  task automatic flag_fault(input string msg);
    fault_count++;
    $display("[%0t] ALARM CHECK: %s", $time, msg);
  endtask

  // Advances the model by one accepted input beat and returns the alarm state
  // the block must report for it.
  function automatic alarm_result_t advance_alarm(input logic func, input logic [15:0] dist_in);
    zone_e            z;
    logic [LEN_W-1:0] interval;
    if (func) begin
      // A tick moves both timers on; they stick at their maximum.
      led_cnt  = (led_cnt == {TW{1'b1}}) ? led_cnt : led_cnt + 1'b1;
      beep_cnt = (beep_cnt == {TW{1'b1}}) ? beep_cnt : beep_cnt + 1'b1;
    end else begin
      if (dist_in < lim_near) begin
        z = ZONE_CLOSE;
      end else if (dist_in < lim_far) begin
        z = ZONE_MID;
      end else begin
        z = ZONE_DISTANT;
      end
      if (z != cur_zone) begin
        // A new zone relights the LED and restarts the beep pattern.
        cur_zone   = z;
        led_lvl    = 1'b1;
        led_cnt    = '0;
        burst_on   = 1'b0;
        beep_on    = 1'b0;
        beeps_made = '0;
        if (z == ZONE_CLOSE || z == ZONE_MID) begin
          beep_goal = (z == ZONE_CLOSE) ? count_near : count_middle;
          on_len    = (z == ZONE_CLOSE) ? near_len : middle_on;
          off_len   = (z == ZONE_CLOSE) ? near_len : MIDDLE_OFF;
          burst_on  = 1'b1;
          beep_on   = 1'b1;
          beep_cnt  = '0;
        end
      end
    end
    // At most one buzzer transition per beat.
    if (burst_on) begin
      if (beep_on) begin
        if (beep_cnt >= on_len) begin
          beep_on    = 1'b0;
          beep_cnt   = '0;
          beeps_made = beeps_made + 1'b1;
          if (beeps_made >= beep_goal) burst_on = 1'b0;
        end
      end else if (beep_cnt >= off_len) begin
        beep_on  = 1'b1;
        beep_cnt = '0;
      end
    end
    // At most one LED transition per beat; far and unknown hold it lit.
    if (cur_zone == ZONE_CLOSE || cur_zone == ZONE_MID) begin
      interval = (cur_zone == ZONE_CLOSE) ? blink_fast : blink_slow;
      if (led_cnt >= interval) begin
        led_cnt = '0;
        led_lvl = ~led_lvl;
      end
    end else begin
      led_lvl = 1'b1;
    end
    return alarm_result_t'{cur_zone, led_lvl, beep_on, burst_on};
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_span();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // Distances cluster around the two limits so that zone edges are hit often,
  // with a share spread over the whole field so that every bit toggles.
  function automatic logic [15:0] pick_distance();
    int r;
    int d;
    r = $urandom_range(0, 9);
    if (r < 4) begin
      d = ((r < 2) ? int'(lim_near) : int'(lim_far)) + int'($urandom_range(0, 6)) - 3;
    end else if (r < 7) begin
      d = $urandom_range(0, int'(lim_far) + 200);
    end else begin
      d = $urandom_range(0, 65535);
    end
    if (d < 0) d = 0;
    if (d > 65535) d = 65535;
    return 16'(d);
  endfunction

  // Register values for one phase. Limits stay in a modest range so that all
  // zones turn up; lengths and counts follow the style of the phase. The
  // unused upper bits of the count registers carry noise.
  function automatic logic [15:0] pick_setting(input cfg_idx_e idx, input setting_style_e style);
    logic [15:0] v;
    case (idx)
      CFG_NEAR_LIMIT, CFG_FAR_LIMIT: begin
        if ($urandom_range(0, 19) == 0) begin
          v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end else begin
          v = 16'($urandom_range(0, 1500));
        end
      end
      CFG_NEAR_COUNT, CFG_MIDDLE_COUNT: begin
        v = 16'($urandom);
        v[3:0] = (style == STYLE_LOW) ? 4'd0 :
                 (style == STYLE_HIGH) ? 4'd15 : 4'($urandom_range(0, 15));
      end
      default: begin
        if (style == STYLE_LOW) begin
          v = 16'h0000;
        end else if (style == STYLE_HIGH || $urandom_range(0, 19) == 0) begin
          v = 16'hFFFF;
        end else begin
          v = 16'($urandom_range(0, 40));
        end
      end
    endcase
    return v;
  endfunction

  function automatic void add_beat(input logic func, input logic [15:0] value,
                                   input logic typed, input alarm_result_t typed_out);
    script_row_t row;
    row.kind      = ROW_BEAT;
    row.func      = func;
    row.value     = value;
    row.reg_sel   = CFG_NEAR_LIMIT;
    row.typed     = typed;
    row.typed_out = typed_out;
    script.push_back(row);
  endfunction

  function automatic void add_reg(input cfg_idx_e idx, input logic [15:0] value);
    script_row_t row;
    row.kind      = ROW_REG;
    row.func      = 1'b0;
    row.value     = value;
    row.reg_sel   = idx;
    row.typed     = 1'b0;
    row.typed_out = UNTYPED;
    script.push_back(row);
  endfunction

  // Offers one input beat, optionally after an idle gap, and records what the
  // block owes for it once the beat is taken. The register port is released
  // here so that a run of writes can keep its valid high between writes.
  task automatic send_beat(input logic func, input logic [15:0] dist_in,
                           input logic typed, input alarm_result_t typed_out);
    alarm_result_t nxt;
    cfg_bus.valid <= 1'b0;
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_bus.valid <= 1'b0;
      repeat (idle_span()) @(posedge clk);
    end
    in_bus.valid       <= 1'b1;
    in_bus.func        <= func;
    in_bus.distance_mm <= dist_in;
    do @(posedge clk); while (!in_bus.ready);
    nxt = advance_alarm(func, dist_in);
    alarm_backlog.push_back(typed ? typed_out : nxt);
  endtask

  // Writes one register once every owed result has been delivered, so no beat
  // is in flight while the setting changes.
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] data);
    in_bus.valid <= 1'b0;
    while (alarm_backlog.size() != 0) @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    case (idx)
      CFG_NEAR_LIMIT:   lim_near     = data;
      CFG_FAR_LIMIT:    lim_far      = data;
      CFG_FAST_BLINK:   blink_fast   = data;
      CFG_SLOW_BLINK:   blink_slow   = data;
      CFG_NEAR_COUNT:   count_near   = data[COUNT_W-1:0];
      CFG_NEAR_BEEP:    near_len     = data;
      CFG_MIDDLE_COUNT: count_middle = data[COUNT_W-1:0];
      CFG_MIDDLE_ON:    middle_on    = data;
      default: ;
    endcase
  endtask

  // Result side: takes beats under a randomly stalling ready and compares each
  // one with the oldest owed alarm state.
  initial begin
    int            hold;
    alarm_result_t want;
    hold = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        results_seen++;
        if (alarm_backlog.size() == 0) begin
          flag_fault($sformatf("result beat %0d arrived with nothing outstanding", results_seen));
        end else begin
          want = alarm_backlog.pop_front();
          if (out_bus.zone !== want.zone)
            flag_fault($sformatf("beat %0d zone %0d, model %0d",
                                 results_seen, out_bus.zone, want.zone));
          if (out_bus.led_on !== want.led_on)
            flag_fault($sformatf("beat %0d led_on %b, model %b",
                                 results_seen, out_bus.led_on, want.led_on));
          if (out_bus.buzzer_on !== want.buzzer_on)
            flag_fault($sformatf("beat %0d buzzer_on %b, model %b",
                                 results_seen, out_bus.buzzer_on, want.buzzer_on));
          if (out_bus.pattern_active !== want.pattern_active)
            flag_fault($sformatf("beat %0d pattern_active %b, model %b",
                                 results_seen, out_bus.pattern_active, want.pattern_active));
        end
      end
      if (hold > 0) begin
        out_bus.ready <= 1'b0;
        hold--;
      end else if (!calm && $urandom_range(0, 99) < 15) begin
        hold = idle_span() - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, the directed script, then random phases each opened by a
  // full set of register writes.
  initial begin
    int             sent;
    int             phase;
    int             quota;
    int             span;
    int             r;
    int             k;
    setting_style_e style;

    rst_n              = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.func        = 1'b0;
    in_bus.distance_mm = '0;
    cfg_bus.valid      = 1'b0;
    cfg_bus.index      = CFG_NEAR_LIMIT;
    cfg_bus.data       = '0;

    lim_near     = NEAR_LIMIT_RST;
    lim_far      = FAR_LIMIT_RST;
    blink_fast   = FAST_BLINK_RST;
    blink_slow   = SLOW_BLINK_RST;
    count_near   = NEAR_COUNT_RST;
    near_len     = NEAR_BEEP_RST;
    count_middle = MIDDLE_COUNT_RST;
    middle_on    = MIDDLE_ON_RST;
    cur_zone     = ZONE_NONE;
    led_lvl      = 1'b1;
    led_cnt      = '0;
    burst_on     = 1'b0;
    beep_on      = 1'b0;
    beep_goal    = '0;
    beeps_made   = '0;
    on_len       = '0;
    off_len      = '0;
    beep_cnt     = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a tick before any sample leaves the zone unknown and the
    // LED lit, and its distance field is ignored.
    add_beat(1'b1, 16'hFFFF, 1'b1, alarm_result_t'{ZONE_NONE, 1'b1, 1'b0, 1'b0});
    // Both sides of each limit; every change of zone starts afresh.
    add_beat(1'b0, 16'd0,    1'b1, alarm_result_t'{ZONE_CLOSE,   1'b1, 1'b1, 1'b1});
    add_beat(1'b0, 16'd99,   1'b0, UNTYPED);
    add_beat(1'b1, 16'd0,    1'b0, UNTYPED);
    add_beat(1'b0, 16'd100,  1'b1, alarm_result_t'{ZONE_MID,     1'b1, 1'b1, 1'b1});
    add_beat(1'b0, 16'd299,  1'b0, UNTYPED);
    add_beat(1'b0, 16'd300,  1'b1, alarm_result_t'{ZONE_DISTANT, 1'b1, 1'b0, 1'b0});
    add_beat(1'b0, 16'hFFFF, 1'b1, alarm_result_t'{ZONE_DISTANT, 1'b1, 1'b0, 1'b0});
    add_beat(1'b1, 16'h5A5A, 1'b1, alarm_result_t'{ZONE_DISTANT, 1'b1, 1'b0, 1'b0});
    // Zero beep count, zero beep length and zero blink interval: everything
    // fires on the very next update and the burst ends after one beep.
    add_reg(CFG_FAST_BLINK, 16'd0);
    add_reg(CFG_NEAR_BEEP,  16'd0);
    add_reg(CFG_NEAR_COUNT, 16'hFFF0);
    add_beat(1'b0, 16'd0, 1'b0, UNTYPED);
    add_beat(1'b1, 16'd0, 1'b0, UNTYPED);
    add_beat(1'b1, 16'd0, 1'b0, UNTYPED);
    // Both limits at zero: every distance is far.
    add_reg(CFG_NEAR_LIMIT, 16'd0);
    add_reg(CFG_FAR_LIMIT,  16'd0);
    add_beat(1'b0, 16'd0, 1'b1, alarm_result_t'{ZONE_DISTANT, 1'b1, 1'b0, 1'b0});
    // Both limits and the near zone settings at their maximum.
    add_reg(CFG_NEAR_LIMIT, 16'hFFFF);
    add_reg(CFG_FAR_LIMIT,  16'hFFFF);
    add_reg(CFG_NEAR_COUNT, 16'h000F);
    add_reg(CFG_NEAR_BEEP,  16'hFFFF);
    add_reg(CFG_FAST_BLINK, 16'hFFFF);
    add_beat(1'b0, 16'hFFFE, 1'b1, alarm_result_t'{ZONE_CLOSE,   1'b1, 1'b1, 1'b1});
    add_beat(1'b0, 16'hFFFF, 1'b1, alarm_result_t'{ZONE_DISTANT, 1'b1, 1'b0, 1'b0});
    // Middle zone with zero count, zero on time and zero blink interval.
    add_reg(CFG_MIDDLE_COUNT, 16'd0);
    add_reg(CFG_MIDDLE_ON,    16'd0);
    add_reg(CFG_SLOW_BLINK,   16'd0);
    add_reg(CFG_NEAR_LIMIT,   16'd10);
    add_reg(CFG_FAR_LIMIT,    16'd20);
    add_beat(1'b0, 16'd15, 1'b0, UNTYPED);
    add_beat(1'b1, 16'd0,  1'b0, UNTYPED);
    add_beat(1'b1, 16'd0,  1'b0, UNTYPED);
    // Short middle beeps against the long near burst, then a few ticks.
    add_reg(CFG_MIDDLE_ON,    16'd2);
    add_reg(CFG_MIDDLE_COUNT, 16'd1);
    add_reg(CFG_SLOW_BLINK,   16'd3);
    add_beat(1'b0, 16'd0,  1'b0, UNTYPED);
    add_beat(1'b0, 16'd15, 1'b0, UNTYPED);
    for (k = 0; k < 4; k++) add_beat(1'b1, 16'($urandom), 1'b0, UNTYPED);

    foreach (script[i]) begin
      if (script[i].kind == ROW_REG) begin
        write_reg(script[i].reg_sel, script[i].value);
      end else begin
        send_beat(script[i].func, script[i].value, script[i].typed, script[i].typed_out);
      end
    end

    // Random phases. The first two take the lowest and highest lengths and
    // counts; the rest mix. Within a phase, samples are followed by runs of
    // ticks of random length, so blinks and bursts play out between samples,
    // and runs of zero length give back-to-back samples.
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_BEATS) begin
      style = (phase == 0) ? STYLE_LOW : (phase == 1) ? STYLE_HIGH : STYLE_MIXED;
      calm <= ($urandom_range(0, 3) == 0);
      for (r = 0; r < 8; r++) write_reg(cfg_idx_e'(r), pick_setting(cfg_idx_e'(r), style));
      quota = $urandom_range(120, 200);
      while (quota > 0) begin
        send_beat(1'b0, pick_distance(), 1'b0, UNTYPED);
        quota--;
        sent++;
        span = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 30) : $urandom_range(31, 120);
        for (k = 0; k < span && quota > 0; k++) begin
          send_beat(1'b1, 16'($urandom), 1'b0, UNTYPED);
          quota--;
          sent++;
        end
      end
      phase++;
    end

    in_bus.valid  <= 1'b0;
    cfg_bus.valid <= 1'b0;
    while (alarm_backlog.size() != 0) @(posedge clk);
    // A couple of pipeline depths more, to catch any stray result beat.
    repeat (8) @(posedge clk);
    if (fault_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: the slowest legal run is well under a tenth of this.
  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
